// ===== hw/rtl/gam_pkg.sv =====
// ----------------------------------------------------------------------------
// gam_pkg
// Shared widths, constants and the saturating add helper of the moving average block.
// ----------------------------------------------------------------------------
package gam_pkg;

  localparam int WINDOW_MAX   = 1024;
  localparam int SLOT_W       = $clog2(WINDOW_MAX);
  localparam int LEN_W        = 11;
  localparam int SAMPLE_W     = 32;
  localparam int SUM_W        = 64;
  localparam int COUNT_W      = 32;
  localparam int ENTRY_W      = SAMPLE_W + 1;
  localparam int DIV_STEPS    = SUM_W;
  localparam int STEP_W       = $clog2(DIV_STEPS);

  localparam logic [LEN_W-1:0] WINDOW_RESET = LEN_W'(22);

  // Signed add that clamps at the limits of the sum width instead of wrapping.
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic signed [SUM_W-1:0] s;
    s = a + b;
    if ((a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1])) begin
      s = a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/gam_if.sv =====
// ----------------------------------------------------------------------------
// gam_in_if / gam_out_if
// Valid/ready channels for samples going in and means coming out.
// ----------------------------------------------------------------------------
interface gam_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gam_pkg::SAMPLE_W-1:0]  sample_value;
  logic                                 sample_present;
  logic                                 series_start;

  modport source (output valid, output sample_value, output sample_present,
                  output series_start, input ready);
  modport sink   (input valid, input sample_value, input sample_present,
                  input series_start, output ready);
endinterface

interface gam_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gam_pkg::SAMPLE_W-1:0]  mean_value;
  logic                                 mean_valid;

  modport source (output valid, output mean_value, output mean_valid, input ready);
  modport sink   (input valid, input mean_value, input mean_valid, output ready);
endinterface

// ===== hw/rtl/gap_aware_moving_average.sv =====
// ----------------------------------------------------------------------------
// gap_aware_moving_average
// Windowed or cumulative mean of Q16.16 samples that skips missing samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one sample per item with a present flag and a series start
//   flag; out_ch returns exactly one result item per input item, in order.
//   cfg_we/cfg_window_length load the window length (zero means cumulative
//   mean); every write also clears the running state. Write it only while idle.
// Sequence:
//   The block works on one item at a time. Each item passes through S_SUB,
//   S_ADD and S_CHK; when the mean is defined, the bit-serial 64-step
//   divider runs in S_DIV before S_OUT, and when no mean is defined S_DIV
//   is skipped. The next item is taken only once the result of the
//   previous one has been loaded into the output register.
// Reset:
//   rst_n clears sum, count, fill level and write slot and sets the window
//   length to 22. The window memory is not cleared; entries are always written
//   before they are read back after a series start.
// Stall:
//   A finished result waits in the output register while out_ch.ready is low.
//   The next item is still accepted and processed, and it stalls only when its
//   own result is ready to be loaded into the occupied output register.
// ----------------------------------------------------------------------------
module gap_aware_moving_average (
  input  logic                           clk,
  input  logic                           rst_n,
  gam_in_if.sink                         in_ch,
  gam_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [gam_pkg::LEN_W-1:0]      cfg_window_length
);

  localparam int SW = gam_pkg::SUM_W;
  localparam int CW = gam_pkg::COUNT_W;
  localparam int XW = gam_pkg::SAMPLE_W;
  localparam int LW = gam_pkg::LEN_W;
  localparam int PW = gam_pkg::SLOT_W;

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for an item; memory read is issued on acceptance
    S_SUB,    // retire the oldest entry of a full window
    S_ADD,    // add the new sample and write it into the window memory
    S_CHK,    // decide whether a mean exists and start the divider
    S_DIV,    // one quotient bit per cycle
    S_OUT     // saturate and hand the result to the output register
  } state_t;

  state_t state_r;

  // Configuration and running state.
  logic [LW-1:0]        len_r;
  logic [PW-1:0]        slot_r;
  logic [LW-1:0]        seen_r;
  logic signed [SW-1:0] sum_r;
  logic [CW-1:0]        cnt_r;

  // Item being worked on.
  logic signed [XW-1:0] x_r;
  logic                 pres_r;
  logic [XW:0]          rd_q_r;
  logic                 res_valid_r;

  // Divider: dividend shifts out of dq_r while quotient bits shift in.
  logic [SW-1:0]        dq_r;
  logic [CW-1:0]        rem_r;
  logic [CW-1:0]        div_r;
  logic                 neg_r;
  logic [gam_pkg::STEP_W-1:0] step_r;

  // Output register.
  logic                 outv_r;
  logic signed [XW-1:0] mean_r;
  logic                 meanv_r;

  // The window memory: bit 32 is the present flag, bits 31..0 the sample.
  logic [XW:0] mem [gam_pkg::WINDOW_MAX];

  logic                 in_fire;
  logic                 cum;
  logic [LW-1:0]        n_eff;
  logic [PW-1:0]        slot_clamped;
  logic [PW-1:0]        rd_addr;
  logic [PW-1:0]        slot_next;
  logic [LW-1:0]        slot_inc;
  logic signed [SW-1:0] sub_sum;
  logic signed [SW-1:0] add_sum;
  logic [SW-1:0]        sum_mag;
  logic                 valid_now;
  logic [XW:0]          rem_sh;
  logic [XW+1:0]        diff;
  logic signed [XW-1:0] sat_q;
  logic                 out_free;
  logic                 out_load;
  logic                 mem_we;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free = !outv_r || out_ch.ready;
  assign out_load = (state_r == S_OUT) && out_free;
  assign mem_we   = (state_r == S_ADD) && !cum;

  assign out_ch.valid      = outv_r;
  assign out_ch.mean_value = mean_r;
  assign out_ch.mean_valid = meanv_r;

  always_comb begin
    cum   = (len_r == '0);
    n_eff = (len_r > LW'(gam_pkg::WINDOW_MAX)) ? LW'(gam_pkg::WINDOW_MAX) : len_r;

    // A slot left beyond the window restarts at the front.
    slot_clamped = ({1'b0, slot_r} >= n_eff) ? '0 : slot_r;
    rd_addr      = in_ch.series_start ? '0 : slot_clamped;

    slot_inc  = {1'b0, slot_r} + LW'(1);
    slot_next = (slot_inc >= n_eff) ? '0 : slot_inc[PW-1:0];

    sub_sum = gam_pkg::sat_add(sum_r, -SW'(signed'(rd_q_r[XW-1:0])));
    add_sum = gam_pkg::sat_add(sum_r, SW'(x_r));
    sum_mag = sum_r[SW-1] ? (~sum_r + SW'(1)) : sum_r;

    valid_now = cum ? pres_r : ((seen_r >= n_eff) && (cnt_r != '0));

    // Restoring division step; the remainder always stays below the divisor.
    rem_sh = {rem_r, dq_r[SW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, div_r};

    // Quotient magnitude to a signed 32-bit mean, clamped at the limits.
    if (neg_r) begin
      if ((dq_r[SW-1:XW] != '0) || (dq_r[XW-1] && (dq_r[XW-2:0] != '0))) begin
        sat_q = {1'b1, {(XW-1){1'b0}}};
      end else begin
        sat_q = -signed'(dq_r[XW-1:0]);
      end
    end else begin
      if (dq_r[SW-1:XW-1] != '0) begin
        sat_q = {1'b0, {(XW-1){1'b1}}};
      end else begin
        sat_q = signed'(dq_r[XW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot_r] <= {pres_r, x_r};
    end
    if (in_fire) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= gam_pkg::WINDOW_RESET;
      slot_r      <= '0;
      seen_r      <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      outv_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      // A new result takes the output register; otherwise a taken one leaves.
      if (out_load) begin
        outv_r <= 1'b1;
      end else if (out_ch.ready) begin
        outv_r <= 1'b0;
      end

      if (cfg_we) begin
        len_r  <= cfg_window_length;
        slot_r <= '0;
        seen_r <= '0;
        sum_r  <= '0;
        cnt_r  <= '0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            x_r    <= in_ch.sample_value;
            pres_r <= in_ch.sample_present;
            if (in_ch.series_start) begin
              slot_r <= '0;
              seen_r <= '0;
              sum_r  <= '0;
              cnt_r  <= '0;
            end else begin
              slot_r <= slot_clamped;
            end
            state_r <= S_SUB;
          end
        end

        S_SUB: begin
          if (!cum) begin
            if (seen_r >= n_eff) begin
              if (rd_q_r[XW]) begin
                sum_r <= sub_sum;
                if (cnt_r != '0) begin
                  cnt_r <= cnt_r - CW'(1);
                end
              end
            end else begin
              seen_r <= seen_r + LW'(1);
            end
          end
          state_r <= S_ADD;
        end

        S_ADD: begin
          if (pres_r) begin
            sum_r <= add_sum;
            if (!cum || (cnt_r != '1)) begin
              cnt_r <= cnt_r + CW'(1);
            end
          end
          if (!cum) begin
            slot_r <= slot_next;
          end
          state_r <= S_CHK;
        end

        S_CHK: begin
          res_valid_r <= valid_now;
          if (valid_now) begin
            dq_r    <= sum_mag;
            rem_r   <= '0;
            div_r   <= cnt_r;
            neg_r   <= sum_r[SW-1];
            step_r  <= '0;
            state_r <= S_DIV;
          end else begin
            neg_r   <= 1'b0;
            state_r <= S_OUT;
          end
        end

        S_DIV: begin
          if (!diff[XW+1]) begin
            rem_r <= diff[CW-1:0];
            dq_r  <= {dq_r[SW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[CW-1:0];
            dq_r  <= {dq_r[SW-2:0], 1'b0};
          end
          step_r <= step_r + gam_pkg::STEP_W'(1);
          if (step_r == gam_pkg::STEP_W'(gam_pkg::DIV_STEPS - 1)) begin
            state_r <= S_OUT;
          end
        end

        S_OUT: begin
          if (out_free) begin
            mean_r  <= res_valid_r ? sat_q : '0;
            meanv_r <= res_valid_r;
            state_r <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/gam_checker.sv =====
// ----------------------------------------------------------------------------
// gam_checker
// Port-level checks of the moving average block, bound to its top level.
// ----------------------------------------------------------------------------
module gam_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [gam_pkg::SAMPLE_W-1:0]   mean_value,
  input logic                           mean_valid
);

  // A result held back by the receiver keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(mean_value) && $stable(mean_valid))
    else $error("stalled result changed");

  // A missing mean always reads as zero.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !mean_valid |-> mean_value == '0)
    else $error("missing mean is not zero");

  // Items are worked on one at a time, so acceptance closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind gap_aware_moving_average gam_checker u_gam_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .mean_value (out_ch.mean_value),
  .mean_valid (out_ch.mean_valid)
);

// ===== test/gam_mean_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gam_mean_checker
// Watches both channels and the window register, predicts every mean and
// compares it with what the moving average block hands out.
// ----------------------------------------------------------------------------
module gam_mean_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  gam_in_if                         in_ch,
  gam_out_if                        out_ch,
  input  logic                      cfg_we,
  input  logic [gam_pkg::LEN_W-1:0] cfg_window_length,
  output int unsigned               outstanding,
  output int unsigned               mismatches
);

  typedef struct packed {
    logic signed [gam_pkg::SAMPLE_W-1:0] mean;
    logic                                valid;
  } mean_t;

  localparam int     SAMPLE_W = gam_pkg::SAMPLE_W;
  localparam int     SUM_W    = gam_pkg::SUM_W;
  localparam longint MEAN_HI  = 64'sd2147483647;
  localparam longint MEAN_LO  = -64'sd2147483648;

  logic [gam_pkg::ENTRY_W-1:0] hist [gam_pkg::WINDOW_MAX];
  int                          slot;
  int                          fill;
  logic signed [SUM_W-1:0]     total;
  logic [gam_pkg::COUNT_W-1:0] tally;
  logic [gam_pkg::LEN_W-1:0]   span_reg;
  mean_t                       mean_queue [$];
  int unsigned                 errors;

  // Sum of two signed values, clamped to the sum width on overflow.
  function automatic logic signed [SUM_W-1:0] clamp_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic [SUM_W:0] wide;
    wide = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      return wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return wide[SUM_W-1:0];
  endfunction

  // Kept sum over kept count, toward zero, clamped to the sample range.
  function automatic logic signed [SAMPLE_W-1:0] kept_mean();
    longint q;
    q = longint'(total) / longint'({32'd0, tally});
    if (q > MEAN_HI) q = MEAN_HI;
    if (q < MEAN_LO) q = MEAN_LO;
    return SAMPLE_W'(q);
  endfunction

  task automatic clear_history();
    slot  = 0;
    fill  = 0;
    total = '0;
    tally = '0;
  endtask

  // One sample goes in, one expected mean comes out.
  task automatic advance_average(
    input  logic signed [SAMPLE_W-1:0] value,
    input  logic                       present,
    input  logic                       start,
    output mean_t                      res
  );
    int                          span;
    logic [gam_pkg::ENTRY_W-1:0] old_entry;
    span = int'(span_reg);
    if (start) clear_history();
    res = '0;
    if (span == 0) begin
      // Cumulative mean: only present samples produce a defined result.
      if (present) begin
        total = clamp_add(total, longint'(value));
        if (tally != '1) tally++;
        res.mean  = kept_mean();
        res.valid = 1'b1;
      end
    end else begin
      if (span > gam_pkg::WINDOW_MAX) span = gam_pkg::WINDOW_MAX;
      if (slot >= span) slot = 0;
      if (fill >= span) begin
        old_entry = hist[slot];
        if (old_entry[SAMPLE_W]) begin
          total = clamp_add(total, -longint'($signed(old_entry[SAMPLE_W-1:0])));
          if (tally != '0) tally--;
        end
      end else begin
        fill++;
      end
      hist[slot] = {present, value};
      if (present) begin
        total = clamp_add(total, longint'(value));
        tally++;
      end
      slot++;
      if (slot >= span) slot = 0;
      if (fill >= span && tally != '0) begin
        res.mean  = kept_mean();
        res.valid = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    mean_t got;
    mean_t want;
    mean_t fresh;
    if (!rst_n) begin
      clear_history();
      span_reg = gam_pkg::WINDOW_RESET;
      mean_queue.delete();
      errors = 0;
      for (int i = 0; i < gam_pkg::WINDOW_MAX; i++) hist[i] = '0;
    end else begin
      if (cfg_we) begin
        span_reg = cfg_window_length;
        clear_history();
      end
      if (out_ch.valid && out_ch.ready) begin
        got.mean  = out_ch.mean_value;
        got.valid = out_ch.mean_valid;
        if (mean_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected mean item: expected none, got value %h valid %b",
                   $time, got.mean, got.valid);
        end else begin
          want = mean_queue.pop_front();
          if (got.mean !== want.mean || got.valid !== want.valid) begin
            errors++;
            $display("%0t: mean mismatch: expected value %h valid %b, got value %h valid %b",
                     $time, want.mean, want.valid, got.mean, got.valid);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        advance_average(in_ch.sample_value, in_ch.sample_present, in_ch.series_start, fresh);
        mean_queue.push_back(fresh);
      end
    end
    outstanding <= mean_queue.size();
    mismatches  <= errors;
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives samples into the gap-aware moving average under several window
// lengths, with random idling on both channels, and reports the verdict of
// the checker that runs beside the block.
// ----------------------------------------------------------------------------
module testbench;

  // No acceptance on either channel for this many cycles means the block hung.
  // The slowest honest stretch is the long receiver hold-off plus a couple of
  // full divider passes, far below this figure.
  localparam int STALL_LIMIT   = 4000;
  // Length of the deliberate receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES   = 400;
  // Quiet time after the last mean, longer than the block's deepest latency.
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASES        = 7;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [gam_pkg::LEN_W-1:0] cfg_window_length;
  int unsigned               outstanding;
  int unsigned               mismatches;
  int unsigned               quiet_cycles  = 0;
  int                        snd_idle_pct  = 17;
  int                        rcv_idle_pct  = 65;
  int                        hold_requests = 0;
  int                        holds_done    = 0;

  gam_in_if  in_ch ();
  gam_out_if out_ch ();

  gap_aware_moving_average uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ch             (in_ch),
    .out_ch            (out_ch),
    .cfg_we            (cfg_we),
    .cfg_window_length (cfg_window_length)
  );

  gam_mean_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ch             (in_ch),
    .out_ch            (out_ch),
    .cfg_we            (cfg_we),
    .cfg_window_length (cfg_window_length),
    .outstanding       (outstanding),
    .mismatches        (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one sample item. The sender may first idle at random, then
  // holds the item until the block takes it. The ready level read right after
  // an edge is the one that decided that edge, so the loop sees acceptance
  // exactly. On return the item has just been accepted and valid is still
  // high, so a following item can go out back to back.
  task automatic offer_sample(
    input logic signed [gam_pkg::SAMPLE_W-1:0] value,
    input logic                                present,
    input logic                                start
  );
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.sample_value   <= value;
    in_ch.sample_present <= present;
    in_ch.series_start   <= start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop offering and wait until every expected mean has come back. The
  // checker's count is registered, hence the first wait.
  task automatic drain_means();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Load a new window length. Only called with the block drained, since every
  // write also wipes the running state.
  task automatic write_window(input logic [gam_pkg::LEN_W-1:0] len);
    cfg_we            <= 1'b1;
    cfg_window_length <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Result side. Normally ready follows the current idle rate; when the
  // stimulus asks for a hold-off, ready stays low for a long counted stretch
  // so that the output register fills and the block stalls its input.
  initial begin : result_sink
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Watchdog: counts cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    // Random phases: window length (negative picks a random short one),
    // item count, percent of present samples, percent of series starts.
    // The 2047 phase runs past a full 1024-entry window so that the clamp
    // to the largest window and the slot wrap both get exercised.
    int                                  lens   [PHASES] = '{5, 0, 1, 2047, 1024, -1, 2};
    int                                  counts [PHASES] = '{120, 80, 40, 1030, 30, 50, 40};
    int                                  pres   [PHASES] = '{70, 60, 50, 85, 80, 25, 50};
    int                                  starts [PHASES] = '{3, 4, 3, 0, 0, 2, 5};
    int                                  total_items;
    int                                  done;
    logic signed [gam_pkg::SAMPLE_W-1:0] v;

    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_window_length    <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.sample_value   <= '0;
    in_ch.sample_present <= 1'b0;
    in_ch.series_start   <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first under the window length left by reset (22).
    // Ten largest samples, two missing ones with busy bit patterns, then ten
    // smallest samples: only the 22nd item completes the first window, and
    // the 23rd pushes the oldest largest sample out again.
    for (int k = 0; k < 10; k++) offer_sample(32'sh7FFFFFFF, 1'b1, 1'b0);
    offer_sample(32'sh55555555, 1'b0, 1'b0);
    offer_sample(32'shAAAAAAAA, 1'b0, 1'b0);
    for (int k = 0; k < 10; k++) offer_sample(32'sh80000000, 1'b1, 1'b0);
    offer_sample('0, 1'b1, 1'b0);

    // Cumulative mean: a missing sample gives no mean, and a series start
    // throws away everything summed before it.
    drain_means();
    write_window('0);
    offer_sample(32'sh7FFFFFFF, 1'b1, 1'b0);
    offer_sample(32'sh12345678, 1'b0, 1'b0);
    offer_sample(32'sh80000000, 1'b1, 1'b1);

    total_items = 0;
    for (int ph = 0; ph < PHASES; ph++) total_items += counts[ph];
    done = 0;

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_means();
      write_window(lens[ph] < 0 ? gam_pkg::LEN_W'($urandom_range(40, 3))
                                : gam_pkg::LEN_W'(lens[ph]));
      for (int k = 0; k < counts[ph]; k++) begin
        // Idle pattern by thirds of the random part: slow receiver, then
        // slow sender, then both at full rate.
        if (done < total_items / 3) begin
          snd_idle_pct = 17;
          rcv_idle_pct = 65;
        end else if (done < 2 * total_items / 3) begin
          snd_idle_pct = 65;
          rcv_idle_pct = 17;
        end else begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
        // Back the block up once while the sender keeps going.
        if (ph == 0 && k == 50) hold_requests++;
        // And once the sender waits for every mean without a config change.
        if (ph == 1 && k == 40) drain_means();

        case ($urandom_range(7))
          0:       v = 32'sh7FFFFFFF;
          1:       v = 32'sh80000000;
          2:       v = int'($urandom_range(196608)) - 98304;
          3:       v = '0;
          default: v = $urandom;
        endcase
        offer_sample(v, $urandom_range(99) < pres[ph], $urandom_range(99) < starts[ph]);
        done++;
      end
    end

    drain_means();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
